// ===== hdl/path_accel_bounds_macros.svh =====
// Assertion helpers for the path acceleration bounds block.
// Each macro expects clk and rst in scope.
`ifndef PATH_ACCEL_BOUNDS_MACROS_SVH
`define PATH_ACCEL_BOUNDS_MACROS_SVH

// Same-cycle implication.
`define PAB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PAB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pab_pkg.sv =====
package pab_pkg;

  localparam int MAX_JOINTS  = 8;
  localparam int MAX_ENTRIES = 1024;
  localparam int JOINT_BITS  = $clog2(MAX_JOINTS);
  localparam int ENTRY_BITS  = $clog2(MAX_ENTRIES);
  localparam int ADDR_BITS   = ENTRY_BITS + JOINT_BITS;
  localparam int TABLE_DEPTH = MAX_ENTRIES * MAX_JOINTS;

  localparam logic [10:0] ENTRY_LIMIT = 11'(MAX_ENTRIES);
  localparam logic [3:0]  JOINT_LIMIT = 4'(MAX_JOINTS);

  // input actions
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_LIMIT = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_DISCR_STEP  = 3'd0;
  localparam logic [2:0] REG_INTEG_STEP  = 3'd1;
  localparam logic [2:0] REG_DURATION    = 3'd2;
  localparam logic [2:0] REG_ENTRY_COUNT = 3'd3;
  localparam logic [2:0] REG_JOINT_COUNT = 3'd4;
  localparam logic [2:0] REG_TINY        = 3'd5;

  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
    logic [31:0]          vel;
    logic [31:0]          acc;
  } pab_wr_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [62:0] divisor;
  } pab_div_req_t;

  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [31:0] quo;
    logic [62:0] rem;
  } pab_div_res_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               hit;
  } pab_sat_t;

  function automatic pab_sat_t sat32(input logic signed [65:0] x);
    pab_sat_t r;
    if (x > 66'sd2147483647) begin
      r.val = 32'sh7fffffff;
      r.hit = 1'b1;
    end else if (x < -66'sd2147483648) begin
      r.val = $signed(32'h80000000);
      r.hit = 1'b1;
    end else begin
      r.val = x[31:0];
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== hdl/pab_tables.sv =====
module pab_tables (
  input  logic                          clk,
  input  pab_pkg::pab_wr_t              wr,
  input  logic [pab_pkg::ADDR_BITS-1:0] rd_addr,
  output logic [31:0]                   rd_vel,
  output logic [31:0]                   rd_acc
);
  import pab_pkg::*;

  logic [31:0] vel_mem [TABLE_DEPTH];
  logic [31:0] acc_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      vel_mem[wr.addr] <= wr.vel;
      acc_mem[wr.addr] <= wr.acc;
    end
    rd_vel <= vel_mem[rd_addr];
    rd_acc <= acc_mem[rd_addr];
  end

endmodule

// ===== hdl/pab_div.sv =====
module pab_div (
  input  logic                  clk,
  input  logic                  rst,
  input  pab_pkg::pab_div_req_t req,
  output pab_pkg::pab_div_res_t res
);
  import pab_pkg::*;

  logic        busy;
  logic [4:0]  cnt;
  logic        done;
  logic        ovf;
  logic [62:0] rem;
  logic [31:0] dq;
  logic [62:0] dvs;
  logic [63:0] trial;
  logic        fit;

  assign trial = {rem, dq[31]};
  assign fit   = trial >= {1'b0, dvs};

  // quotient must fit 32 bits; otherwise flag overflow, but run the full count
  // so that both lanes always finish on the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ovf  <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        dvs  <= req.divisor;
        ovf  <= ({31'b0, req.dividend[63:32]} >= req.divisor);
        busy <= 1'b1;
        cnt  <= 5'd31;
        rem  <= {31'b0, req.dividend[63:32]};
        dq   <= req.dividend[31:0];
      end else if (busy) begin
        rem <= fit ? 63'(trial - {1'b0, dvs}) : trial[62:0];
        dq  <= {dq[30:0], fit};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.ovf  = ovf;
  assign res.quo  = dq;
  assign res.rem  = rem;

endmodule

// ===== hdl/path_accel_bounds.sv =====
// Sequencing: a load or limit write is stored from its accepted beat; a query
// shows its result beat once the bit-per-cycle dividers are through: three
// setup divisions, only two when the position uses the last entry, then one
// parallel pair per active joint; a joint skipped as near zero needs no
// division.
// Throughput: one item at a time; the next item is taken once the sequencer
// is back in idle, which it reaches at the edge that loads the result beat,
// even while that beat waits at the output.
// Reset: rst (synchronous) restores the register defaults and clears control;
// tables and joint limits hold no reset value.
`include "path_accel_bounds_macros.svh"

module path_accel_bounds (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic [9:0]         entry_index,
  input  logic [2:0]         joint_index,
  input  logic signed [31:0] velocity_coeff,
  input  logic signed [31:0] accel_coeff,
  input  logic [30:0]        limit_value,
  input  logic [30:0]        position,
  input  logic [30:0]        path_speed,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] lower_bound,
  output logic signed [31:0] upper_bound,
  output logic               saturated
);
  import pab_pkg::*;

  // sequencer codes
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_MUL     = 5'd1;
  localparam logic [4:0] S_SB_GO   = 5'd2;
  localparam logic [4:0] S_SB_WAIT = 5'd3;
  localparam logic [4:0] S_IX_GO   = 5'd4;
  localparam logic [4:0] S_IX_WAIT = 5'd5;
  localparam logic [4:0] S_CF_GO   = 5'd6;
  localparam logic [4:0] S_CF_WAIT = 5'd7;
  localparam logic [4:0] S_RD0     = 5'd8;
  localparam logic [4:0] S_RD1     = 5'd9;
  localparam logic [4:0] S_MIX     = 5'd10;
  localparam logic [4:0] S_SUM     = 5'd11;
  localparam logic [4:0] S_PROD    = 5'd12;
  localparam logic [4:0] S_NUM     = 5'd13;
  localparam logic [4:0] S_JD_GO   = 5'd14;
  localparam logic [4:0] S_JD_WAIT = 5'd15;
  localparam logic [4:0] S_DONE    = 5'd16;

  // configuration registers
  logic [30:0] discr_step;
  logic [30:0] integration_step;
  logic [30:0] duration;
  logic [10:0] entry_count;
  logic [3:0]  joint_count;
  logic [15:0] tiny_threshold;

  // effective configuration: zero steps act as one, counts clamp to the tables
  logic [30:0] d_eff;
  logic [30:0] h_eff;
  logic [10:0] ne_eff;
  logic [10:0] last_entry;
  logic [3:0]  nj_eff;

  assign d_eff  = (discr_step == '0) ? 31'd1 : discr_step;
  assign h_eff  = (integration_step == '0) ? 31'd1 : integration_step;
  assign ne_eff = (entry_count == '0) ? 11'd1 :
                  (entry_count > ENTRY_LIMIT) ? ENTRY_LIMIT : entry_count;
  assign last_entry = ne_eff - 11'd1;
  assign nj_eff = (joint_count > JOINT_LIMIT) ? JOINT_LIMIT : joint_count;

  logic [4:0]  state;
  logic        accept;
  logic        load_ok;

  // query working registers
  logic [30:0]          s_q;
  logic [30:0]          sd_q;
  logic [61:0]          hh;
  logic [61:0]          sqr;
  logic signed [31:0]   sdsq;
  logic signed [31:0]   alpha;
  logic signed [31:0]   beta;
  logic                 sat_flag;
  logic [ENTRY_BITS-1:0] i0;
  logic [ENTRY_BITS-1:0] i1;
  logic [30:0]          rem_s;
  logic [15:0]          coef;
  logic [JOINT_BITS-1:0] j;
  logic signed [31:0]   v0;
  logic signed [31:0]   a0;
  logic signed [49:0]   pv;
  logic signed [49:0]   pa;
  logic signed [31:0]   qd;
  logic signed [31:0]   qdd;
  logic signed [63:0]   pm;
  logic signed [31:0]   prod;
  logic                 lo_neg;
  logic                 hi_neg;

  logic [30:0] joint_limits [MAX_JOINTS];

  pab_wr_t      tbl_wr;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [31:0]  rd_vel;
  logic [31:0]  rd_acc;
  pab_div_req_t div0_req;
  pab_div_req_t div1_req;
  pab_div_res_t div0_res;
  pab_div_res_t div1_res;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_ok  = !out_valid || !out_stall;

  // table write straight from an accepted load beat
  assign tbl_wr.en   = accept && (action == ACT_LOAD);
  assign tbl_wr.addr = {entry_index, joint_index};
  assign tbl_wr.vel  = velocity_coeff;
  assign tbl_wr.acc  = accel_coeff;

  // RD0 fetches the lower entry, every other state the upper one
  assign rd_addr = (state == S_RD0) ? {i0, j} : {i1, j};

  pab_tables u_tables (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr (rd_addr),
    .rd_vel  (rd_vel),
    .rd_acc  (rd_acc)
  );

  // per-joint numerators; the sign of qd swaps which one bounds from below
  logic signed [33:0] am34;
  logic signed [33:0] pr34;
  logic signed [33:0] n_neg;
  logic signed [33:0] n_pos;
  logic signed [33:0] lo_num;
  logic signed [33:0] hi_num;
  logic [31:0]        lo_mag;
  logic [31:0]        hi_mag;
  logic [31:0]        qd_mag;

  assign am34   = $signed({3'b0, joint_limits[j]});
  assign pr34   = {{2{prod[31]}}, prod};
  assign n_neg  = -am34 - pr34;
  assign n_pos  = am34 - pr34;
  assign lo_num = qd[31] ? n_pos : n_neg;
  assign hi_num = qd[31] ? n_neg : n_pos;
  assign lo_mag = lo_num[33] ? 32'(-lo_num) : lo_num[31:0];
  assign hi_mag = hi_num[33] ? 32'(-hi_num) : hi_num[31:0];
  assign qd_mag = qd[31] ? (~qd + 32'd1) : qd;

  // share lane 0 between the setup divisions and the lower bound
  always_comb begin
    div0_req = '0;
    div1_req = '0;
    unique case (state)
      S_SB_GO: begin
        div0_req.start    = 1'b1;
        div0_req.dividend = {1'b0, d_eff, 32'b0};
        div0_req.divisor  = {1'b0, hh};
      end
      S_IX_GO: begin
        div0_req.start    = 1'b1;
        div0_req.dividend = {33'b0, s_q};
        div0_req.divisor  = {32'b0, d_eff};
      end
      S_CF_GO: begin
        div0_req.start    = 1'b1;
        div0_req.dividend = {17'b0, rem_s, 16'b0};
        div0_req.divisor  = {32'b0, d_eff};
      end
      S_JD_GO: begin
        div0_req.start    = 1'b1;
        div0_req.dividend = {16'b0, lo_mag, 16'b0};
        div0_req.divisor  = {31'b0, qd_mag};
        div1_req.start    = 1'b1;
        div1_req.dividend = {16'b0, hi_mag, 16'b0};
        div1_req.divisor  = {31'b0, qd_mag};
      end
      default: begin
      end
    endcase
  end

  pab_div u_div_lo (
    .clk (clk),
    .rst (rst),
    .req (div0_req),
    .res (div0_res)
  );

  pab_div u_div_hi (
    .clk (clk),
    .rst (rst),
    .req (div1_req),
    .res (div1_res)
  );

  // safety bound from lane 0: overflow or a set top bit saturates
  pab_sat_t sb_sat;
  assign sb_sat = sat32(div0_res.ovf ? 66'sd4294967296 : {34'b0, div0_res.quo});

  // index split and end detection
  logic use_last;
  assign use_last = (({1'b0, s_q} + {16'b0, tiny_threshold}) >= {1'b0, duration}) ||
                    (div0_res.quo >= {21'b0, last_entry});

  // interpolation sums
  logic signed [34:0] qd_sum;
  logic signed [34:0] qdd_sum;
  assign qd_sum  = {{3{v0[31]}}, v0} + {pv[49], pv[49:16]};
  assign qdd_sum = {{3{a0[31]}}, a0} + {pa[49], pa[49:16]};

  logic signed [32:0] dv;
  logic signed [32:0] da;
  assign dv = {rd_vel[31], rd_vel} - {v0[31], v0};
  assign da = {rd_acc[31], rd_acc} - {a0[31], a0};

  logic tiny_qd;
  assign tiny_qd = qd_mag <= {16'b0, tiny_threshold};

  pab_sat_t sdsq_sat;
  pab_sat_t prod_sat;
  assign sdsq_sat = sat32({20'b0, sqr[61:16]});
  assign prod_sat = sat32({{18{pm[63]}}, pm[63:16]});

  // signed per-joint bounds; truncation toward zero comes from sign-magnitude
  logic signed [65:0] lo_qx;
  logic signed [65:0] hi_qx;
  pab_sat_t lo_sat;
  pab_sat_t hi_sat;
  assign lo_qx  = div0_res.ovf ? 66'sd4294967296 : {34'b0, div0_res.quo};
  assign hi_qx  = div1_res.ovf ? 66'sd4294967296 : {34'b0, div1_res.quo};
  assign lo_sat = sat32(lo_neg ? -lo_qx : lo_qx);
  assign hi_sat = sat32(hi_neg ? -hi_qx : hi_qx);

  logic last_joint;
  assign last_joint = ({1'b0, j} + 4'd1) >= nj_eff;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      discr_step       <= 31'd65536;
      integration_step <= 31'd65536;
      duration         <= '0;
      entry_count      <= 11'd1;
      joint_count      <= 4'd1;
      tiny_threshold   <= 16'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DISCR_STEP:  discr_step       <= cfg_data;
        REG_INTEG_STEP:  integration_step <= cfg_data;
        REG_DURATION:    duration         <= cfg_data;
        REG_ENTRY_COUNT: entry_count      <= cfg_data[10:0];
        REG_JOINT_COUNT: joint_count      <= cfg_data[3:0];
        REG_TINY:        tiny_threshold   <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // joint limits: written by a limit beat, read one joint at a time
  always_ff @(posedge clk) begin
    if (accept && (action == ACT_LIMIT)) begin
      joint_limits[joint_index] <= limit_value;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      sat_flag <= 1'b0;
      j        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && (action == ACT_QUERY)) begin
            s_q   <= position;
            sd_q  <= path_speed;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          hh       <= h_eff * h_eff;
          sqr      <= sd_q * sd_q;
          sat_flag <= 1'b0;
          state    <= S_SB_GO;
        end
        S_SB_GO: begin
          sdsq     <= sdsq_sat.val;
          sat_flag <= sat_flag | sdsq_sat.hit;
          state    <= S_SB_WAIT;
        end
        S_SB_WAIT: begin
          if (div0_res.done) begin
            alpha    <= -sb_sat.val;
            beta     <= sb_sat.val;
            sat_flag <= sat_flag | sb_sat.hit;
            state    <= S_IX_GO;
          end
        end
        S_IX_GO: begin
          state <= S_IX_WAIT;
        end
        S_IX_WAIT: begin
          if (div0_res.done) begin
            j <= '0;
            if (use_last) begin
              // hold on the last loaded entry
              i0    <= last_entry[ENTRY_BITS-1:0];
              i1    <= last_entry[ENTRY_BITS-1:0];
              coef  <= '0;
              state <= (nj_eff == 4'd0) ? S_DONE : S_RD0;
            end else begin
              i0    <= div0_res.quo[ENTRY_BITS-1:0];
              i1    <= ENTRY_BITS'(div0_res.quo + 32'd1);
              rem_s <= div0_res.rem[30:0];
              state <= S_CF_GO;
            end
          end
        end
        S_CF_GO: begin
          state <= S_CF_WAIT;
        end
        S_CF_WAIT: begin
          if (div0_res.done) begin
            coef  <= div0_res.quo[15:0];
            state <= (nj_eff == 4'd0) ? S_DONE : S_RD0;
          end
        end
        S_RD0: begin
          state <= S_RD1;
        end
        S_RD1: begin
          v0    <= rd_vel;
          a0    <= rd_acc;
          state <= S_MIX;
        end
        S_MIX: begin
          pv    <= dv * $signed({1'b0, coef});
          pa    <= da * $signed({1'b0, coef});
          state <= S_SUM;
        end
        S_SUM: begin
          qd    <= qd_sum[31:0];
          qdd   <= qdd_sum[31:0];
          state <= S_PROD;
        end
        S_PROD: begin
          if (tiny_qd) begin
            // drop joints with a near-zero velocity coefficient
            if (last_joint) begin
              state <= S_DONE;
            end else begin
              j     <= j + 1'b1;
              state <= S_RD0;
            end
          end else begin
            pm    <= sdsq * qdd;
            state <= S_NUM;
          end
        end
        S_NUM: begin
          prod     <= prod_sat.val;
          sat_flag <= sat_flag | prod_sat.hit;
          state    <= S_JD_GO;
        end
        S_JD_GO: begin
          lo_neg <= lo_num[33] ^ qd[31];
          hi_neg <= hi_num[33] ^ qd[31];
          state  <= S_JD_WAIT;
        end
        S_JD_WAIT: begin
          if (div0_res.done) begin
            if (lo_sat.val > alpha) alpha <= lo_sat.val;
            if (hi_sat.val < beta) beta <= hi_sat.val;
            sat_flag <= sat_flag | lo_sat.hit | hi_sat.hit;
            if (last_joint) begin
              state <= S_DONE;
            end else begin
              j     <= j + 1'b1;
              state <= S_RD0;
            end
          end
        end
        S_DONE: begin
          // wait for the output register to free up
          if (load_ok) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register: parts the sequencer from the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && load_ok) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && load_ok) begin
      lower_bound <= alpha;
      upper_bound <= beta;
      saturated   <= sat_flag;
    end
  end

  `PAB_ASSERT_NOW(a_accept_idle, !in_stall, state == S_IDLE, "input taken outside idle")
  `PAB_ASSERT_NEXT(a_done_shows, (state == S_DONE) && load_ok, out_valid, "result beat lost")
  `PAB_ASSERT_NOW(a_lanes_align, div1_res.done, div0_res.done, "divider lanes out of step")
  `PAB_ASSERT_NEXT(a_hold_result, out_valid && out_stall, $stable(lower_bound) && $stable(upper_bound), "stalled result moved")

endmodule
